// ===== src/sbpa_pkg.sv =====
// Shared types, codes and defaults for the segregated block pool allocator.
`timescale 1ns / 1ps

package sbpa_pkg;

  localparam int ADDR_W      = 24;
  localparam int REQ_W       = 16;
  localparam int LOG2_W      = 4;
  localparam int CLS_W       = 2;
  localparam int NUM_CLASSES = 3;
  localparam int CFG_IDX_W   = 2;

  localparam int HEADER_BYTES_DEF  = 8;
  localparam int CLASS0_BLOCKS_DEF = 8;
  localparam int CLASS1_BLOCKS_DEF = 8;
  localparam int CLASS2_BLOCKS_DEF = 4;

  localparam logic [ADDR_W-1:0] BASE_RST     = '0;
  localparam logic [LOG2_W-1:0] LOG2_RST [NUM_CLASSES] = '{4'd4, 4'd5, 4'd6};

  typedef enum logic {
    OP_ALLOC,
    OP_FREE
  } op_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_EXHAUSTED,
    ST_NO_FIT,
    ST_BAD_ADDR,
    ST_DOUBLE_FREE
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE,
    CFG_LOG2_0,
    CFG_LOG2_1,
    CFG_LOG2_2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_LOOKUP,
    S_COMMIT
  } state_t;

  typedef struct packed {
    op_t               operation;
    logic [REQ_W-1:0]  request_size;
    logic [ADDR_W-1:0] block_address;
  } request_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] granted_address;
    logic [CLS_W-1:0]  class_index;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic decode;
    logic lookup;
    logic commit;
    logic pop;
    logic push;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_free;
    logic lookup_err;
    logic blk_busy;
  } stat_t;

endpackage

// ===== src/sbpa_ctrl.sv =====
// Sequencing state machine for the pool allocator.
`timescale 1ns / 1ps

module sbpa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  sbpa_pkg::stat_t stat,
  output sbpa_pkg::cmd_t  cmd,
  output logic          busy,
  output logic          done
);
  import sbpa_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_COMMIT);
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = S_LOOKUP;
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        // errors found at lookup leave the lists alone; a free of an idle block too
        cmd.pop    = !stat.lookup_err && !stat.is_free;
        cmd.push   = !stat.lookup_err && stat.is_free && stat.blk_busy;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== src/sbpa_datapath.sv =====
// Config registers, free lists, link store and address arithmetic of the allocator.
`timescale 1ns / 1ps

module sbpa_datapath #(
  parameter int HEADER_BYTES  = sbpa_pkg::HEADER_BYTES_DEF,
  parameter int CLASS0_BLOCKS = sbpa_pkg::CLASS0_BLOCKS_DEF,
  parameter int CLASS1_BLOCKS = sbpa_pkg::CLASS1_BLOCKS_DEF,
  parameter int CLASS2_BLOCKS = sbpa_pkg::CLASS2_BLOCKS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [sbpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sbpa_pkg::ADDR_W-1:0]        cfg_data,
  input  sbpa_pkg::request_t                 request,
  input  sbpa_pkg::cmd_t                     cmd,
  output sbpa_pkg::stat_t                    stat,
  output sbpa_pkg::result_t                  result
);
  import sbpa_pkg::*;

  localparam int TOTAL = CLASS0_BLOCKS + CLASS1_BLOCKS + CLASS2_BLOCKS;
  localparam int BW    = $clog2(TOTAL);
  localparam int BSZ_W = (1 << LOG2_W) + 1;
  localparam int CNT   [NUM_CLASSES] = '{CLASS0_BLOCKS, CLASS1_BLOCKS, CLASS2_BLOCKS};
  localparam int FIRST [NUM_CLASSES] = '{0, CLASS0_BLOCKS, CLASS0_BLOCKS + CLASS1_BLOCKS};

  // configuration
  logic [ADDR_W-1:0] base_address;
  logic [LOG2_W-1:0] log2_r [NUM_CLASSES];

  // captured word and decode results
  op_t               op_r;
  logic [REQ_W-1:0]  req_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] hdr_r;
  logic [ADDR_W-1:0] start_r [NUM_CLASSES];
  logic [ADDR_W-1:0] span_r  [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] fit_r;

  // lookup results
  logic [CLS_W-1:0] cls_r;
  logic [BW-1:0]    g_r;
  logic [BW-1:0]    local_r;
  status_t          code_r;

  // free list state
  logic [BW-1:0]          head_r [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] head_v;
  logic [TOTAL-1:0]       in_use;
  logic [TOTAL-1:0]       wr_mark;
  logic [BW:0]            link_mem [TOTAL];
  logic [BW:0]            link_rd;

  // combinational
  logic [ADDR_W-1:0] span_c [NUM_CLASSES];
  logic [BSZ_W-1:0]  bsz_c  [NUM_CLASSES];
  logic [ADDR_W-1:0] off_c  [NUM_CLASSES];
  logic [ADDR_W-1:0] mask_c [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] hit_c;
  logic              a_any, f_any;
  logic [CLS_W-1:0]  a_sel, f_sel;
  logic [BW-1:0]     f_local;
  logic [BW-1:0]     rd_addr;
  logic              pop_last_ok;
  logic [BW-1:0]     pop_link;
  logic              pop_valid;
  logic [ADDR_W-1:0] grant_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= BASE_RST;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        log2_r[c] <= LOG2_RST[c];
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE:   base_address <= cfg_data;
        CFG_LOG2_0: log2_r[0]    <= cfg_data[LOG2_W-1:0];
        CFG_LOG2_1: log2_r[1]    <= cfg_data[LOG2_W-1:0];
        CFG_LOG2_2: log2_r[2]    <= cfg_data[LOG2_W-1:0];
        default:    base_address <= base_address;
      endcase
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      span_c[c] = ADDR_W'(CNT[c]) << log2_r[c];
      bsz_c[c]  = BSZ_W'(1) << log2_r[c];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= request.operation;
      req_r  <= request.request_size;
      addr_r <= request.block_address;
    end
    if (cmd.decode) begin
      hdr_r      <= addr_r - ADDR_W'(HEADER_BYTES);
      start_r[0] <= base_address;
      start_r[1] <= base_address + span_c[0];
      start_r[2] <= base_address + span_c[0] + span_c[1];
      for (int c = 0; c < NUM_CLASSES; c++) begin
        span_r[c] <= span_c[c];
        fit_r[c]  <= (bsz_c[c] >= BSZ_W'(HEADER_BYTES)) &&
                     (BSZ_W'(req_r) <= bsz_c[c] - BSZ_W'(HEADER_BYTES));
      end
    end
  end

  // class search: first fitting class for an allocate, owning range for a free
  always_comb begin
    a_any = 1'b0;
    a_sel = '0;
    f_any = 1'b0;
    f_sel = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      off_c[c]  = hdr_r - start_r[c];
      mask_c[c] = (ADDR_W'(1) << log2_r[c]) - ADDR_W'(1);
      hit_c[c]  = (off_c[c] < span_r[c]) && ((off_c[c] & mask_c[c]) == '0);
      if (fit_r[c]) begin
        a_any = 1'b1;
        a_sel = CLS_W'(c);
      end
      if (hit_c[c]) begin
        f_any = 1'b1;
        f_sel = CLS_W'(c);
      end
    end
    f_local = BW'(off_c[f_sel] >> log2_r[f_sel]);
    rd_addr = head_r[a_sel];
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      link_rd <= link_mem[rd_addr];
      if (op_r == OP_ALLOC) begin
        g_r     <= head_r[a_sel];
        local_r <= head_r[a_sel] - BW'(FIRST[a_sel]);
        if (!a_any) begin
          code_r <= ST_NO_FIT;
          cls_r  <= '0;
        end else begin
          code_r <= head_v[a_sel] ? ST_OK : ST_EXHAUSTED;
          cls_r  <= a_sel;
        end
      end else begin
        g_r     <= BW'(FIRST[f_sel]) + f_local;
        local_r <= f_local;
        code_r  <= f_any ? ST_OK : ST_BAD_ADDR;
        cls_r   <= f_any ? f_sel : '0;
      end
    end
    if (cmd.push) begin
      link_mem[g_r] <= {head_v[cls_r], head_r[cls_r]};
    end
  end

  // an unwritten link entry reads as its reset link: the next block of the class
  always_comb begin
    pop_last_ok = ((BW+1)'(local_r) + (BW+1)'(1)) < (BW+1)'(CNT[cls_r]);
    pop_link    = wr_mark[g_r] ? link_rd[BW-1:0] : g_r + BW'(1);
    pop_valid   = wr_mark[g_r] ? link_rd[BW] : pop_last_ok;
    grant_c     = start_r[cls_r] + (ADDR_W'(local_r) << log2_r[cls_r]) +
                  ADDR_W'(HEADER_BYTES);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_r[c] <= BW'(FIRST[c]);
      end
      head_v  <= '1;
      in_use  <= '0;
      wr_mark <= '0;
    end else if (cmd.pop) begin
      head_r[cls_r] <= pop_link;
      head_v[cls_r] <= pop_valid;
      in_use[g_r]   <= 1'b1;
    end else if (cmd.push) begin
      head_r[cls_r] <= g_r;
      head_v[cls_r] <= 1'b1;
      in_use[g_r]   <= 1'b0;
      wr_mark[g_r]  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result.class_index     <= cls_r;
      result.granted_address <= cmd.pop ? grant_c : '0;
      if (code_r != ST_OK) begin
        result.status <= code_r;
      end else if (op_r == OP_FREE && !in_use[g_r]) begin
        result.status <= ST_DOUBLE_FREE;
      end else begin
        result.status <= ST_OK;
      end
    end
  end

  assign stat.is_free    = (op_r == OP_FREE);
  assign stat.lookup_err = (code_r != ST_OK);
  assign stat.blk_busy   = in_use[g_r];

endmodule

// ===== src/segregated_block_pool_allocator_core.sv =====
// Top level of the segregated fixed-block pool allocator.
`timescale 1ns / 1ps
// Usage
//   Request channel: drive request and raise start; the word is taken at the
//   clock edge where start is high and busy is low. busy stays high until the
//   reply is out. An allocate gets a header-skipped block address from the
//   first size class that fits; a free hands an address back.
//   Reply channel: done is high for exactly one cycle with result valid in
//   that cycle. There is no back-pressure; the receiver must take it.
//   Steps: from acceptance to done a word passes capture, decode of class
//   start addresses, class lookup plus link store read, and list update.
//   busy drops in the cycle done shows, so a new word may be taken then;
//   only one word is in flight at a time.
//   Config: cfg_we, cfg_index, cfg_data write base_address or one of the
//   three class size log2 registers per write; write only while idle. Lists
//   hold block numbers, so a layout change moves addresses, not lists.
//   Reset (rst, synchronous): config to defaults, every class list back to
//   address order, all blocks free. No clearing pass is needed; the link
//   store reads its reset link until an entry is written by a free.
module segregated_block_pool_allocator_core #(
  parameter int HEADER_BYTES  = sbpa_pkg::HEADER_BYTES_DEF,
  parameter int CLASS0_BLOCKS = sbpa_pkg::CLASS0_BLOCKS_DEF,
  parameter int CLASS1_BLOCKS = sbpa_pkg::CLASS1_BLOCKS_DEF,
  parameter int CLASS2_BLOCKS = sbpa_pkg::CLASS2_BLOCKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sbpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sbpa_pkg::ADDR_W-1:0]    cfg_data,
  input  logic                           start,
  input  sbpa_pkg::request_t             request,
  output logic                           busy,
  output logic                           done,
  output sbpa_pkg::result_t              result
);
  import sbpa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer: one word in flight, four states
  sbpa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // lists, link store, config and address maths
  sbpa_datapath #(
    .HEADER_BYTES  (HEADER_BYTES),
    .CLASS0_BLOCKS (CLASS0_BLOCKS),
    .CLASS1_BLOCKS (CLASS1_BLOCKS),
    .CLASS2_BLOCKS (CLASS2_BLOCKS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .request   (request),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

endmodule

// ===== src/sbpa_checker.sv =====
// Port-level checks for the pool allocator, bound to the top level.
`timescale 1ns / 1ps

module sbpa_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input sbpa_pkg::result_t  result
);
  import sbpa_pkg::*;

  // an accepted word is answered by done
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("reply not four cycles after acceptance");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after acceptance");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("reply outside the end of a job");

  a_err_no_grant: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_OK) |-> (result.granted_address == '0))
    else $error("address granted on a failed request");

  a_no_class: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ST_NO_FIT || result.status == ST_BAD_ADDR))
      |-> (result.class_index == '0))
    else $error("class named on a request that found none");

endmodule

bind segregated_block_pool_allocator_core sbpa_checker u_sbpa_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
